// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the plane layout RTL. Every macro samples on the
// rising edge of clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define POL_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the trigger holds, the condition holds at the next clock edge.
`define POL_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== src/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Types, constants and codes shared by the plane offset layout modules.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int WORD_W      = 64;
   localparam int GRAIN_BYTES = 64;
   localparam int MAX_PLANES  = 16;
   localparam int PLANES_W    = 5;
   localparam int ERR_W       = 3;
   localparam int STEP_W      = $clog2(WORD_W);
   localparam int REM_W       = $clog2(GRAIN_BYTES + 1);

   localparam logic [WORD_W-1:0] GRAIN_PAD  = WORD_W'(GRAIN_BYTES - 1);
   localparam logic [WORD_W-1:0] GRAIN_WORD = WORD_W'(GRAIN_BYTES);
   localparam bit GRAIN_IS_POW2 = ((GRAIN_BYTES & (GRAIN_BYTES - 1)) == 0);

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 3'd0,
      ERR_PLANES  = 3'd1,
      ERR_HEADER  = 3'd2,
      ERR_PRODUCT = 3'd3,
      ERR_ROUND   = 3'd4,
      ERR_SUM     = 3'd5
   } pol_err_type;

   // Operations of the shared adder datapath.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_HDR_PAD,
      OP_HDR_ROUND,
      OP_MUL_INIT,
      OP_MUL_STEP,
      OP_PAD,
      OP_MOD_STEP,
      OP_ROUND,
      OP_SUM
   } pol_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDR_PAD,
      S_HDR_MOD,
      S_HDR_ROUND,
      S_PLANE,
      S_MUL,
      S_PAD,
      S_MOD,
      S_ROUND,
      S_SUM,
      S_DONE
   } pol_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] element_count;
      logic [WORD_W-1:0] element_size;
      logic              last_plane;
      logic              no_plane;
   } pol_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] plane_offset;
      logic [WORD_W-1:0] running_total;
      logic [ERR_W-1:0]  error_code;
      logic              layout_done;
   } pol_rsp_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic carry;
      logic mul_ovf;
      logic step_last;
   } pol_stat_type;

   // Sequencer request to load the result word.
   typedef struct packed {
      logic        load;
      pol_err_type err;
      logic        last;
   } pol_rsp_ctl_type;

endpackage

// ===== src/plane_offset_layout.sv =====
// ----------------------------------------------------------------------------
// plane_offset_layout
// Computes grain-aligned plane offsets and the running block size of a layout.
// ----------------------------------------------------------------------------
// Each request word describes one plane (element count and element size) or,
// with no_plane set, no plane at all; last_plane closes the layout. The first
// word of a layout starts the total at csr header_bytes rounded up to the
// grain. Every word gets exactly one response word with the plane's offset,
// the running total, the first error of the layout and a copy of last_plane;
// offset and total read 0 once an error has occurred. The block works on one
// word at a time and raises req_stall while busy. Its speed is set by a
// single shared 64-bit adder that also serves as a bit-serial multiplier: a
// plane word runs the serial multiply of count by size, one step per bit,
// then pads, rounds and adds to the total. The first word of a layout first
// pads and rounds the header, and skips the rounding when the padded header
// would wrap. A word without a plane, or one arriving after an error or past
// the plane limit, skips the multiply and goes straight to its response.
// With a grain that is not a power of two, each rounding also runs a serial
// remainder through the same adder. A finished response sits
// in an output register, so the next request word is taken while that
// response still waits behind rsp_stall; the block only holds in its final
// state when a second response is ready and the register is still full.
// header_bytes may be written only while the block is idle and takes effect
// at the start of the next layout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plane_offset_layout import pol_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pol_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pol_rsp_type       rsp_data,
   input  logic              csr_write_en,
   input  logic [WORD_W-1:0] csr_write_data
);

   logic [WORD_W-1:0] header_ff,    header_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pol_rsp_type       rsp_data_ff,  rsp_data_in;

   pol_op_type        op;
   pol_stat_type      stat;
   pol_rsp_ctl_type   rsp_ctl;
   logic [WORD_W-1:0] offset;
   logic [WORD_W-1:0] total;
   logic              out_free;

   // The output register can take a new word when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   pol_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_plane),
      .req_none  (req_data.no_plane),
      .out_free  (out_free),
      .stat      (stat),
      .req_stall (req_stall),
      .op        (op),
      .rsp_ctl   (rsp_ctl)
   );

   pol_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .item   (req_data),
      .header (header_ff),
      .stat   (stat),
      .offset (offset),
      .total  (total)
   );

   always_comb begin
      header_in    = csr_write_en ? csr_write_data : header_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ctl.load) begin
         rsp_valid_in = 1'b1;
         // After an error, offset and total both read zero.
         if (rsp_ctl.err != ERR_NONE) begin
            rsp_data_in.plane_offset  = '0;
            rsp_data_in.running_total = '0;
         end else begin
            rsp_data_in.plane_offset  = offset;
            rsp_data_in.running_total = total;
         end
         rsp_data_in.error_code  = rsp_ctl.err;
         rsp_data_in.layout_done = rsp_ctl.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new response word is never written over one that is still stalled.
   `POL_ASSERT(a_no_overwrite, !(rsp_ctl.load && rsp_valid_ff && rsp_stall), "stalled word lost")

endmodule

// ===== src/pol_dp.sv =====
// ----------------------------------------------------------------------------
// pol_dp
// Datapath around one shared 64-bit adder: serial multiply, grain padding,
// serial remainder, rounding and accumulation of the running total.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pol_dp import pol_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  pol_op_type        op,
   input  pol_req_type       item,
   input  logic [WORD_W-1:0] header,
   output pol_stat_type      stat,
   output logic [WORD_W-1:0] offset,
   output logic [WORD_W-1:0] total
);

   logic [WORD_W-1:0] acc_ff,    acc_in;
   logic [WORD_W-1:0] total_ff,  total_in;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0] mcand_ff,  mcand_in;
   logic [WORD_W-1:0] mplier_ff, mplier_in;
   logic [REM_W-1:0]  rem_ff,    rem_in;
   logic [STEP_W-1:0] cnt_ff,    cnt_in;
   logic              ovf_ff,    ovf_in;

   logic [WORD_W-1:0] a_op;
   logic [WORD_W-1:0] b_op;
   logic              cin;
   logic [WORD_W:0]   sum;
   logic [REM_W:0]    rem_shift;
   logic [WORD_W-1:0] rem_sel;
   logic              mul_ovf;

   // Remainder bit-serial, most significant bit of the padded value first.
   assign rem_shift = {rem_ff, acc_ff[~cnt_ff]};
   assign rem_sel   = GRAIN_IS_POW2 ? (acc_ff & GRAIN_PAD) : WORD_W'(rem_ff);

   always_comb begin
      a_op = '0;
      b_op = '0;
      cin  = 1'b0;
      case (op)
         OP_HDR_PAD: begin
            a_op = header;
            b_op = GRAIN_PAD;
         end
         OP_MUL_STEP: begin
            a_op = {acc_ff[WORD_W-2:0], 1'b0};
            b_op = mplier_ff[WORD_W-1] ? mcand_ff : '0;
         end
         OP_PAD: begin
            a_op = acc_ff;
            b_op = GRAIN_PAD;
         end
         OP_MOD_STEP: begin
            a_op = WORD_W'(rem_shift);
            b_op = ~GRAIN_WORD;
            cin  = 1'b1;
         end
         OP_HDR_ROUND, OP_ROUND: begin
            a_op = acc_ff;
            b_op = ~rem_sel;
            cin  = 1'b1;
         end
         OP_SUM: begin
            a_op = total_ff;
            b_op = acc_ff;
         end
         default: begin
            a_op = '0;
         end
      endcase
   end

   assign sum     = {1'b0, a_op} + {1'b0, b_op} + (WORD_W+1)'(cin);
   assign mul_ovf = ovf_ff | acc_ff[WORD_W-1] | sum[WORD_W];

   always_comb begin
      acc_in    = acc_ff;
      total_in  = total_ff;
      offset_in = offset_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      case (op)
         OP_LOAD: begin
            mplier_in = item.element_count;
            mcand_in  = item.element_size;
            offset_in = '0;
         end
         OP_HDR_PAD, OP_PAD: begin
            acc_in = sum[WORD_W-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
         OP_MOD_STEP: begin
            // A carry out means the shifted remainder reached the grain.
            rem_in = sum[WORD_W] ? sum[REM_W-1:0] : rem_shift[REM_W-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         OP_HDR_ROUND: begin
            total_in = sum[WORD_W-1:0];
         end
         OP_MUL_INIT: begin
            acc_in = '0;
            ovf_in = 1'b0;
            cnt_in = '0;
         end
         OP_MUL_STEP: begin
            acc_in    = sum[WORD_W-1:0];
            ovf_in    = mul_ovf;
            mplier_in = {mplier_ff[WORD_W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
         end
         OP_ROUND: begin
            acc_in = sum[WORD_W-1:0];
         end
         OP_SUM: begin
            if (!sum[WORD_W]) begin
               offset_in = total_ff;
               total_in  = sum[WORD_W-1:0];
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      total_ff  <= total_in;
      offset_ff <= offset_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      ovf_ff    <= ovf_in;
   end

   assign stat.carry     = sum[WORD_W];
   assign stat.mul_ovf   = mul_ovf;
   assign stat.step_last = (cnt_ff == STEP_W'(WORD_W - 1));
   assign offset         = offset_ff;
   assign total          = total_ff;

   // Once the product has overflowed, later steps must not lose that fact.
   `POL_ASSERT_NEXT(a_ovf_sticky, (op == OP_MUL_STEP) && ovf_ff, ovf_ff, "multiply overflow lost")

endmodule

// ===== src/pol_seq.sv =====
// ----------------------------------------------------------------------------
// pol_seq
// Sequencer for the plane layout: steps the shared datapath through header
// rounding, serial multiply, rounding and accumulation, and tracks the layout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pol_seq import pol_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   input  logic            req_none,
   input  logic            out_free,
   input  pol_stat_type    stat,
   output logic            req_stall,
   output pol_op_type      op,
   output pol_rsp_ctl_type rsp_ctl
);

   pol_state_type        state_ff,     state_in;
   logic                 in_layout_ff, in_layout_in;
   logic [PLANES_W-1:0]  planes_ff,    planes_in;
   pol_err_type          err_ff,       err_in;
   logic                 last_ff,      last_in;
   logic                 none_ff,      none_in;
   logic                 planes_full;

   assign planes_full = (planes_ff >= PLANES_W'(MAX_PLANES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = in_layout_ff ? S_PLANE : S_HDR_PAD;
            end
         end
         S_HDR_PAD: begin
            if (stat.carry) begin
               state_in = S_PLANE;
            end else begin
               state_in = GRAIN_IS_POW2 ? S_HDR_ROUND : S_HDR_MOD;
            end
         end
         S_HDR_MOD: begin
            if (stat.step_last) begin
               state_in = S_HDR_ROUND;
            end
         end
         S_HDR_ROUND: begin
            state_in = S_PLANE;
         end
         S_PLANE: begin
            if (none_ff || (err_ff != ERR_NONE) || planes_full) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (stat.step_last) begin
               state_in = stat.mul_ovf ? S_DONE : S_PAD;
            end
         end
         S_PAD: begin
            if (stat.carry) begin
               state_in = S_DONE;
            end else begin
               state_in = GRAIN_IS_POW2 ? S_ROUND : S_MOD;
            end
         end
         S_MOD: begin
            if (stat.step_last) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath operation and handshake outputs.
   always_comb begin
      op = OP_IDLE;
      case (state_ff)
         S_IDLE:      op = req_valid ? OP_LOAD : OP_IDLE;
         S_HDR_PAD:   op = OP_HDR_PAD;
         S_HDR_MOD:   op = OP_MOD_STEP;
         S_HDR_ROUND: op = OP_HDR_ROUND;
         S_PLANE:     op = OP_MUL_INIT;
         S_MUL:       op = OP_MUL_STEP;
         S_PAD:       op = OP_PAD;
         S_MOD:       op = OP_MOD_STEP;
         S_ROUND:     op = OP_ROUND;
         S_SUM:       op = OP_SUM;
         default:     op = OP_IDLE;
      endcase
      req_stall    = (state_ff != S_IDLE);
      rsp_ctl.load = (state_ff == S_DONE) && out_free;
      rsp_ctl.err  = err_ff;
      rsp_ctl.last = last_ff;
   end

   // Layout bookkeeping.
   always_comb begin
      in_layout_in = in_layout_ff;
      planes_in    = planes_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      none_in      = none_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               none_in = req_none;
               if (!in_layout_ff) begin
                  in_layout_in = 1'b1;
                  planes_in    = '0;
                  err_in       = ERR_NONE;
               end
            end
         end
         S_HDR_PAD: begin
            if (stat.carry) begin
               err_in = ERR_HEADER;
            end
         end
         S_PLANE: begin
            if (!none_ff && (err_ff == ERR_NONE) && planes_full) begin
               err_in = ERR_PLANES;
            end
         end
         S_MUL: begin
            if (stat.step_last && stat.mul_ovf) begin
               err_in = ERR_PRODUCT;
            end
         end
         S_PAD: begin
            if (stat.carry) begin
               err_in = ERR_ROUND;
            end
         end
         S_SUM: begin
            if (stat.carry) begin
               err_in = ERR_SUM;
            end else begin
               planes_in = planes_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free && last_ff) begin
               in_layout_in = 1'b0;
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_layout_ff <= 1'b0;
         planes_ff    <= '0;
         err_ff       <= ERR_NONE;
         last_ff      <= 1'b0;
         none_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_layout_ff <= in_layout_in;
         planes_ff    <= planes_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         none_ff      <= none_in;
      end
   end

   // An error stays put for the rest of its layout.
   `POL_ASSERT_NEXT(a_err_sticky, (err_ff != ERR_NONE) && in_layout_ff, err_ff == $past(err_ff), "error code changed inside a layout")
   // The plane count never passes the limit.
   `POL_ASSERT(a_planes_bound, planes_ff <= PLANES_W'(MAX_PLANES), "plane count above limit")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for plane_offset_layout: directed corner layouts, then
// random layouts under random sender gaps and receiver stalls, every response
// word compared field by field against an in-bench layout predictor.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the layout state, works out the response
// word for every accepted request word and checks the responses in order.
class layout_scoreboard;
   localparam logic [pol_pkg::WORD_W-1:0] ALL_ONES = '1;

   logic [pol_pkg::WORD_W-1:0] header_cfg;
   logic [pol_pkg::WORD_W-1:0] layout_total;
   int unsigned                planes_laid;
   pol_pkg::pol_err_type       sticky_err;
   bit                         layout_open;
   pol_pkg::pol_rsp_type       awaited_words[$];
   int unsigned                fail_count;
   int unsigned                words_checked;

   function new();
      header_cfg    = '0;
      layout_total  = '0;
      planes_laid   = 0;
      sticky_err    = pol_pkg::ERR_NONE;
      layout_open   = 1'b0;
      fail_count    = 0;
      words_checked = 0;
   endfunction

   // Callers guarantee x + pad cannot wrap.
   function logic [pol_pkg::WORD_W-1:0] grain_up(logic [pol_pkg::WORD_W-1:0] x);
      return ((x + pol_pkg::GRAIN_PAD) / pol_pkg::GRAIN_WORD) * pol_pkg::GRAIN_WORD;
   endfunction

   // Advances the layout by one accepted request word and queues its response.
   function void lay_out_plane(pol_pkg::pol_req_type w);
      logic [2*pol_pkg::WORD_W-1:0] product;
      logic [pol_pkg::WORD_W-1:0]   padded;
      logic [pol_pkg::WORD_W-1:0]   offset;
      pol_pkg::pol_rsp_type         r;
      offset = '0;
      if (!layout_open) begin
         layout_open  = 1'b1;
         planes_laid  = 0;
         sticky_err   = pol_pkg::ERR_NONE;
         layout_total = '0;
         if (header_cfg > ALL_ONES - pol_pkg::GRAIN_PAD) begin
            sticky_err = pol_pkg::ERR_HEADER;
         end else begin
            layout_total = grain_up(header_cfg);
         end
      end
      if (!w.no_plane && sticky_err == pol_pkg::ERR_NONE) begin
         product = {64'd0, w.element_count} * {64'd0, w.element_size};
         if (planes_laid >= pol_pkg::MAX_PLANES) begin
            sticky_err = pol_pkg::ERR_PLANES;
         end else if (product[2*pol_pkg::WORD_W-1:pol_pkg::WORD_W] != '0) begin
            sticky_err = pol_pkg::ERR_PRODUCT;
         end else if (product[pol_pkg::WORD_W-1:0] > ALL_ONES - pol_pkg::GRAIN_PAD) begin
            sticky_err = pol_pkg::ERR_ROUND;
         end else begin
            padded = grain_up(product[pol_pkg::WORD_W-1:0]);
            if (layout_total > ALL_ONES - padded) begin
               sticky_err = pol_pkg::ERR_SUM;
            end else begin
               offset       = layout_total;
               layout_total = layout_total + padded;
               planes_laid++;
            end
         end
      end
      if (sticky_err != pol_pkg::ERR_NONE) begin
         r.plane_offset  = '0;
         r.running_total = '0;
      end else begin
         r.plane_offset  = offset;
         r.running_total = layout_total;
      end
      r.error_code  = sticky_err;
      r.layout_done = w.last_plane;
      awaited_words.push_back(r);
      if (w.last_plane) begin
         layout_open = 1'b0;
      end
   endfunction

   task report(string msg);
      $display("[%0t] layout check: %s", $time, msg);
      fail_count++;
   endtask

   task check_offsets(pol_pkg::pol_rsp_type got);
      pol_pkg::pol_rsp_type want;
      if (awaited_words.size() == 0) begin
         report($sformatf("unexpected response word offset %h total %h err %0d",
                          got.plane_offset, got.running_total, got.error_code));
         return;
      end
      want = awaited_words.pop_front();
      if (got.plane_offset !== want.plane_offset) begin
         report($sformatf("word %0d plane_offset %h, expected %h", words_checked,
                          got.plane_offset, want.plane_offset));
      end
      if (got.running_total !== want.running_total) begin
         report($sformatf("word %0d running_total %h, expected %h", words_checked,
                          got.running_total, want.running_total));
      end
      if (got.error_code !== want.error_code) begin
         report($sformatf("word %0d error_code %0d, expected %0d", words_checked,
                          got.error_code, want.error_code));
      end
      if (got.layout_done !== want.layout_done) begin
         report($sformatf("word %0d layout_done %b, expected %b", words_checked,
                          got.layout_done, want.layout_done));
      end
      words_checked++;
   endtask
endclass

module tb;
   import pol_pkg::*;

   // Roughly this many request words are sent in total.
   localparam int unsigned RANDOM_WORDS = 1350;
   // Far above what a clean run needs, even with gaps and stalls, so this
   // limit only trips on a hang.
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pol_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pol_rsp_type       rsp_data;
   logic              csr_write_en;
   logic [WORD_W-1:0] csr_write_data;

   layout_scoreboard sb = new();

   // Idle levels per side: 0 means none, 1 light, 2 heavy.
   int unsigned req_idle = 0;
   int unsigned rsp_idle = 0;
   int unsigned words_sent = 0;
   int unsigned cycle_count = 0;

   plane_offset_layout u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // Watchdog. A hang, or responses that never arrive, end the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response monitor. Inputs only move on the falling edge, so everything
   // sampled here at the rising edge is the settled pre-edge value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_offsets(rsp_data);
      end
   end

   // Receiver backpressure. Heavy mode keeps the output register full for
   // long stretches so that short words pile up behind it.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_idle != 0 && $urandom_range(0, rsp_idle == 1 ? 7 : 1) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [WORD_W-1:0] wide_word();
      return {$urandom, $urandom};
   endfunction

   function automatic pol_req_type plane_word(logic [WORD_W-1:0] count,
                                              logic [WORD_W-1:0] size,
                                              logic last, logic none);
      pol_req_type w;
      w.element_count = count;
      w.element_size  = size;
      w.last_plane    = last;
      w.no_plane      = none;
      return w;
   endfunction

   // Presents one request word and returns at the falling edge after it was
   // taken. Valid is left high there so a following word can go out without
   // a bubble; whoever waits next lowers it first.
   task automatic send_word(pol_req_type w);
      if (req_idle != 0 && $urandom_range(0, req_idle == 1 ? 7 : 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.lay_out_plane(w);
      words_sent++;
      @(negedge clock);
   endtask

   // Waits until every response has come back, then lets the given number of quiet cycles pass.
   task automatic settle(int unsigned quiet);
      req_valid <= 1'b0;
      while (sb.awaited_words.size() != 0) @(negedge clock);
      repeat (quiet) @(negedge clock);
   endtask

   task automatic write_header(logic [WORD_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      sb.header_cfg   = value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // One random layout. Most are well formed with small sizes so that the
   // arithmetic runs to the end; some carry huge fields to provoke the wrap
   // errors, some run past the plane limit, a few are empty.
   task automatic send_layout();
      int unsigned       planes;
      bit                wild;
      bit                last;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] size;
      if ($urandom_range(0, 11) == 0) begin
         send_word(plane_word(wide_word(), wide_word(), 1'b1, 1'b1));
         return;
      end
      planes = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
      wild   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < planes; i++) begin
         last = (i == planes - 1);
         // Words without a plane carry random junk in the ignored fields.
         if ($urandom_range(0, 9) == 0) begin
            send_word(plane_word(wide_word(), wide_word(), last, 1'b1));
            continue;
         end
         count = WORD_W'($urandom_range(0, 4096));
         size  = WORD_W'($urandom_range(0, 1 << 20));
         if ($urandom_range(0, 15) == 0) begin
            count = '0;
         end
         if ((wild && $urandom_range(0, 2) != 0) || $urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 4))
               0: begin
                  count = wide_word();
                  size  = wide_word();
               end
               1: begin
                  // Right at the rounding limit.
                  count = 64'd1;
                  size  = ALL_ONES - WORD_W'($urandom_range(0, 127));
               end
               2: begin
                  // Powers of two straddle the 64-bit product boundary.
                  count = 64'd1 << $urandom_range(0, 63);
                  size  = 64'd1 << $urandom_range(0, 63);
               end
               3: begin
                  count = wide_word();
                  size  = WORD_W'($urandom_range(0, 3));
               end
               default: begin
                  count = wide_word() >> $urandom_range(0, 63);
                  size  = wide_word() >> $urandom_range(0, 63);
               end
            endcase
         end
         send_word(plane_word(count, size, last, 1'b0));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed layouts with a zero header.
      write_header('0);
      // An empty layout, element fields at their maximum and ignored.
      send_word(plane_word(ALL_ONES, ALL_ONES, 1'b1, 1'b1));
      // A small plane, a zero-count plane sharing the next offset, a word
      // without a plane in the middle, then a plane of 2^33 bytes.
      send_word(plane_word(64'd3, 64'd5, 1'b0, 1'b0));
      send_word(plane_word('0, ALL_ONES, 1'b0, 1'b0));
      send_word(plane_word(ALL_ONES, '0, 1'b0, 1'b1));
      send_word(plane_word(64'd2, 64'd1 << 32, 1'b1, 1'b0));
      // Product wrap, and the word after it only repeats the error.
      send_word(plane_word(64'd1 << 32, 64'd1 << 32, 1'b0, 1'b0));
      send_word(plane_word(64'd1, 64'd1, 1'b1, 1'b0));
      // Rounding wrap.
      send_word(plane_word(ALL_ONES, 64'd1, 1'b1, 1'b0));
      // The largest plane that still fits.
      send_word(plane_word(64'd1, ALL_ONES - GRAIN_PAD, 1'b1, 1'b0));

      // The smallest header that wraps when rounded.
      settle(4);
      write_header(ALL_ONES - GRAIN_PAD + 64'd1);
      send_word(plane_word('0, '0, 1'b1, 1'b0));

      // The largest header that fits, then one byte more overflows the sum.
      settle(4);
      write_header(ALL_ONES - GRAIN_PAD);
      send_word(plane_word('0, '0, 1'b0, 1'b0));
      send_word(plane_word(64'd1, 64'd1, 1'b1, 1'b0));

      // One plane more than the limit.
      settle(4);
      write_header(64'd1);
      for (int i = 0; i <= MAX_PLANES; i++) begin
         send_word(plane_word(WORD_W'($urandom_range(0, 9)),
                              WORD_W'($urandom_range(0, 200)),
                              i == MAX_PLANES, 1'b0));
      end

      // Random phases. Each one settles, rewrites the header and picks new
      // idle levels; the last stretch of the run goes without any idling.
      while (words_sent < RANDOM_WORDS) begin
         settle(4);
         case ($urandom_range(0, 9))
            0:       write_header('0);
            1:       write_header(ALL_ONES);
            2:       write_header(ALL_ONES - GRAIN_PAD);
            3:       write_header(ALL_ONES - GRAIN_PAD + 64'd1);
            4:       write_header(wide_word());
            5:       write_header(ALL_ONES - WORD_W'($urandom_range(64, 1 << 24)));
            default: write_header(WORD_W'($urandom_range(0, 100000)));
         endcase
         if (words_sent + 150 >= RANDOM_WORDS) begin
            req_idle = 0;
            rsp_idle = 0;
         end else begin
            req_idle = $urandom_range(0, 2);
            rsp_idle = $urandom_range(0, 2);
         end
         repeat ($urandom_range(2, 10)) send_layout();
      end

      // Drain, then give the block time to show any stray response.
      settle(80);
      if (sb.fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
